### hdl/snv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snv_pkg
// Shared payload types and fixed constants of the vector refraction block.
// ----------------------------------------------------------------------------
package snv_pkg;

   // Component and index formats that do not vary.
   localparam int COMP_W   = 16;
   localparam int IOR_W    = 14;
   localparam int IOR_FRAC = 12;

   localparam logic [IOR_W-1:0] IOR_ONE   = 14'd4096;
   localparam logic [IOR_W-1:0] IOR_RESET = 14'd6144;

   localparam logic signed [COMP_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [COMP_W-1:0] SAT_MIN = -16'sh8000;

   // One ray-surface hit.
   typedef struct packed {
      logic signed [COMP_W-1:0] dir_x;
      logic signed [COMP_W-1:0] dir_y;
      logic signed [COMP_W-1:0] dir_z;
      logic signed [COMP_W-1:0] norm_x;
      logic signed [COMP_W-1:0] norm_y;
      logic signed [COMP_W-1:0] norm_z;
   } req_type;

   // One refracted direction.
   typedef struct packed {
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic signed [COMP_W-1:0] out_z;
      logic                     refracted;
   } rsp_type;

endpackage

### hdl/snell_vector_refraction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snell_vector_refraction
// Snell's-law refraction of a unit ray at a surface in Q2.14 fixed point.
// ----------------------------------------------------------------------------
// Usage:
// A request transfer (req_valid high, req_stall low) carries a ray direction
// and a surface normal. Each request yields exactly one response transfer in
// order: the refracted direction, or zeros with refracted low on total
// internal reflection.
// Throughput is one transfer per cycle while neither the divider nor rsp_stall
// holds the flow. The pipeline has four front stages, FRAC_BITS + 1 square
// root stages with one root bit each, and two output stages.
// The index register is written through csr_we / csr_data; the user must write
// it only while the block is idle, and the block itself does not enforce this.
// After reset and after each write, req_stall stays high while the entering
// index ratio is divided out, one quotient bit per cycle.
// When rsp_stall holds a waiting response, the whole pipeline freezes and
// req_stall rises; no transfer is lost or repeated.
// Reset is synchronous and active high; the index returns to 1.5.
// ----------------------------------------------------------------------------
module snell_vector_refraction #(
   parameter int FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  snv_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output snv_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [snv_pkg::IOR_W-1:0]  csr_data
);
   import snv_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int NW     = F + 2;
   localparam int SIDE_W = 1 + 2 * NW + 3 * 16 + 3 * 17;

   logic               en, busy, in_valid;
   logic [NW-1:0]      n_in, n_out;
   logic               f_valid, f_tir;
   logic [2*F:0]       f_rad;
   logic [NW-1:0]      f_nc, f_n;
   logic signed [15:0] f_dx, f_dy, f_dz;
   logic signed [16:0] f_nx, f_ny, f_nz;
   logic [SIDE_W-1:0]  side_in, side_out;
   logic               s_valid;
   logic [F:0]         s_root;
   logic               b_tir;
   logic [NW-1:0]      b_nc, b_n;
   logic signed [15:0] b_dx, b_dy, b_dz;
   logic signed [16:0] b_nx, b_ny, b_nz;

   // The pipeline moves unless a finished response is held back.
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = busy || !en;
   assign in_valid  = req_valid && !busy;

   snv_recip #(.FRAC_BITS(F)) u_recip (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .n_in     (n_in),
      .n_out    (n_out),
      .busy     (busy)
   );

   snv_front #(.FRAC_BITS(F)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .in_data   (req_data),
      .n_in      (n_in),
      .n_out     (n_out),
      .out_valid (f_valid),
      .rad       (f_rad),
      .tir       (f_tir),
      .nc_f      (f_nc),
      .n         (f_n),
      .dx        (f_dx),
      .dy        (f_dy),
      .dz        (f_dz),
      .nx        (f_nx),
      .ny        (f_ny),
      .nz        (f_nz)
   );

   // Everything the output stages need rides along with the root.
   assign side_in = {f_tir, f_nc, f_n, f_dx, f_dy, f_dz, f_nx, f_ny, f_nz};

   snv_sqrt #(.FRAC_BITS(F), .SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_rad    (f_rad),
      .in_side   (side_in),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (side_out)
   );

   assign {b_tir, b_nc, b_n, b_dx, b_dy, b_dz, b_nx, b_ny, b_nz} = side_out;

   snv_back #(.FRAC_BITS(F)) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .root      (s_root),
      .tir       (b_tir),
      .nc_f      (b_nc),
      .n         (b_n),
      .dx        (b_dx),
      .dy        (b_dy),
      .dz        (b_dz),
      .nx        (b_nx),
      .ny        (b_ny),
      .nz        (b_nz),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/snv_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snv_recip
// Holds the index register and derives both index ratios from it, the
// entering one with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module snv_recip #(
   parameter int FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [snv_pkg::IOR_W-1:0]    csr_data,
   output logic [FRAC_BITS+1:0]         n_in,
   output logic [FRAC_BITS+1:0]         n_out,
   output logic                         busy
);
   import snv_pkg::*;

   localparam int NW   = FRAC_BITS + 2;
   localparam int QW   = FRAC_BITS + 1;
   localparam int CNTW = $clog2(FRAC_BITS + 1);
   localparam int REMW = IOR_W + 2;
   localparam int SHL  = (FRAC_BITS >= IOR_FRAC) ? FRAC_BITS - IOR_FRAC : 0;
   localparam int SHR  = (FRAC_BITS < IOR_FRAC) ? IOR_FRAC - FRAC_BITS : 0;
   localparam logic [REMW-1:0] REM_START = REMW'(1) << IOR_FRAC;

   logic [IOR_W-1:0] ior_ff, ior_in;
   logic [REMW-1:0]  rem_ff, rem_in, rem_sub;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             ge;

   // One quotient bit of 2^(F+12) / index per cycle; a write restarts it.
   always_comb begin
      ge      = rem_ff >= REMW'(ior_ff);
      rem_sub = ge ? rem_ff - REMW'(ior_ff) : rem_ff;
      ior_in  = ior_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (csr_we) begin
         ior_in  = (csr_data < IOR_ONE) ? IOR_ONE : csr_data;
         rem_in  = REM_START;
         quo_in  = '0;
         cnt_in  = CNTW'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[QW-2:0], ge};
         rem_in = rem_sub << 1;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ior_ff  <= IOR_RESET;
         rem_ff  <= REM_START;
         quo_ff  <= '0;
         cnt_ff  <= CNTW'(FRAC_BITS);
         busy_ff <= 1'b1;
      end else begin
         ior_ff  <= ior_in;
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // Leaving the material the ratio is the index itself, rescaled.
   always_comb begin
      n_in = NW'(quo_ff);
      if (FRAC_BITS >= IOR_FRAC) begin
         n_out = NW'(ior_ff) << SHL;
      end else begin
         n_out = NW'(ior_ff >> SHR);
      end
   end

   assign busy = busy_ff;

endmodule

### hdl/snv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snv_front
// Four pipeline stages: products, clamped dot and side select, squares,
// and the discriminant with its total internal reflection flag.
// ----------------------------------------------------------------------------
module snv_front #(
   parameter int FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  snv_pkg::req_type           in_data,
   input  logic [FRAC_BITS+1:0]       n_in,
   input  logic [FRAC_BITS+1:0]       n_out,
   output logic                       out_valid,
   output logic [2*FRAC_BITS:0]       rad,
   output logic                       tir,
   output logic [FRAC_BITS+1:0]       nc_f,
   output logic [FRAC_BITS+1:0]       n,
   output logic signed [15:0]         dx,
   output logic signed [15:0]         dy,
   output logic signed [15:0]         dz,
   output logic signed [16:0]         nx,
   output logic signed [16:0]         ny,
   output logic signed [16:0]         nz
);
   import snv_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int NW   = F + 2;
   localparam int CW   = F + 1;
   localparam int DW   = (2 * F + 2 > 34) ? 2 * F + 2 : 34;
   localparam int SQW  = 2 * F + 2;
   localparam int N2W  = F + 4;
   localparam int KW   = 2 * F + 5;
   localparam int XW   = 2 * F + 1;
   localparam logic [DW-1:0]  ONE_D = DW'(1) << (2 * F);
   localparam logic [SQW-1:0] ONE_S = SQW'(1) << (2 * F);
   localparam logic [KW-1:0]  ONE_K = KW'(1) << (2 * F);

   // Stage 1: component products.
   logic              v1_ff;
   logic signed [31:0] p0_ff, p1_ff, p2_ff;
   req_type           r1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= in_data.dir_x * in_data.norm_x;
         p1_ff <= in_data.dir_y * in_data.norm_y;
         p2_ff <= in_data.dir_z * in_data.norm_z;
         r1_ff <= in_data;
      end
   end

   // Stage 2: clamped dot, cosine, side of the surface.
   logic signed [DW-1:0] dot, dcl;
   logic [DW-1:0]        cosv;
   logic                 leaving;
   logic                 v2_ff;
   logic [CW-1:0]        cos2_ff;
   logic [NW-1:0]        n2_ff;
   logic signed [15:0]   d2x_ff, d2y_ff, d2z_ff;
   logic signed [16:0]   m2x_ff, m2y_ff, m2z_ff;

   always_comb begin
      dot = DW'(p0_ff) + DW'(p1_ff) + DW'(p2_ff);
      dcl = dot;
      if (dot > $signed(ONE_D)) begin
         dcl = $signed(ONE_D);
      end else if (dot < -$signed(ONE_D)) begin
         dcl = -$signed(ONE_D);
      end
      leaving = !dcl[DW-1];
      cosv    = leaving ? dcl : -dcl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos2_ff <= CW'(cosv >> F);
         n2_ff   <= leaving ? n_out : n_in;
         d2x_ff  <= r1_ff.dir_x;
         d2y_ff  <= r1_ff.dir_y;
         d2z_ff  <= r1_ff.dir_z;
         m2x_ff  <= leaving ? -17'(r1_ff.norm_x) : 17'(r1_ff.norm_x);
         m2y_ff  <= leaving ? -17'(r1_ff.norm_y) : 17'(r1_ff.norm_y);
         m2z_ff  <= leaving ? -17'(r1_ff.norm_z) : 17'(r1_ff.norm_z);
      end
   end

   // Stage 3: n squared, one minus cosine squared, n times cosine.
   logic [2*NW-1:0]    nn, ncos;
   logic [SQW-1:0]     csq, sin2;
   logic               v3_ff;
   logic [N2W-1:0]     nsq3_ff;
   logic [CW-1:0]      s3_ff;
   logic [NW-1:0]      nc3_ff, n3_ff;
   logic signed [15:0] d3x_ff, d3y_ff, d3z_ff;
   logic signed [16:0] m3x_ff, m3y_ff, m3z_ff;

   always_comb begin
      nn   = (2 * NW)'(n2_ff) * (2 * NW)'(n2_ff);
      ncos = (2 * NW)'(n2_ff) * (2 * NW)'(cos2_ff);
      csq  = SQW'(cos2_ff) * SQW'(cos2_ff);
      sin2 = ONE_S - csq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nsq3_ff <= N2W'(nn >> F);
         s3_ff   <= CW'(sin2 >> F);
         nc3_ff  <= NW'(ncos >> F);
         n3_ff   <= n2_ff;
         d3x_ff  <= d2x_ff;
         d3y_ff  <= d2y_ff;
         d3z_ff  <= d2z_ff;
         m3x_ff  <= m2x_ff;
         m3y_ff  <= m2y_ff;
         m3z_ff  <= m2z_ff;
      end
   end

   // Stage 4: discriminant and total internal reflection.
   logic [KW-1:0]      k;
   logic               v4_ff, tir4_ff;
   logic [XW-1:0]      rad4_ff;
   logic [NW-1:0]      nc4_ff, n4_ff;
   logic signed [15:0] d4x_ff, d4y_ff, d4z_ff;
   logic signed [16:0] m4x_ff, m4y_ff, m4z_ff;

   assign k = KW'(nsq3_ff) * KW'(s3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tir4_ff <= k > ONE_K;
         rad4_ff <= XW'(ONE_K - k);
         nc4_ff  <= nc3_ff;
         n4_ff   <= n3_ff;
         d4x_ff  <= d3x_ff;
         d4y_ff  <= d3y_ff;
         d4z_ff  <= d3z_ff;
         m4x_ff  <= m3x_ff;
         m4y_ff  <= m3y_ff;
         m4z_ff  <= m3z_ff;
      end
   end

   assign out_valid = v4_ff;
   assign rad       = rad4_ff;
   assign tir       = tir4_ff;
   assign nc_f      = nc4_ff;
   assign n         = n4_ff;
   assign dx        = d4x_ff;
   assign dy        = d4y_ff;
   assign dz        = d4z_ff;
   assign nx        = m4x_ff;
   assign ny        = m4y_ff;
   assign nz        = m4z_ff;

endmodule

### hdl/snv_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snv_sqrt
// Pipelined integer square root, one root bit per stage, with side data
// carried alongside each item.
// ----------------------------------------------------------------------------
module snv_sqrt #(
   parameter int FRAC_BITS = 14,
   parameter int SIDE_W    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [2*FRAC_BITS:0]   in_rad,
   input  logic [SIDE_W-1:0]      in_side,
   output logic                   out_valid,
   output logic [FRAC_BITS:0]     out_root,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int F    = FRAC_BITS;
   localparam int XW   = 2 * F + 1;
   localparam int RESW = 2 * F + 2;
   localparam int RW   = F + 1;

   logic [XW-1:0]     x_ff    [0:F];
   logic [RESW-1:0]   res_ff  [0:F];
   logic [SIDE_W-1:0] side_ff [0:F];
   logic              v_ff    [0:F];

   for (genvar s = 0; s <= F; s++) begin : g_stage
      localparam logic [RESW-1:0] BIT = RESW'(1) << (2 * (F - s));
      logic [XW-1:0]     x_src, x_in;
      logic [RESW-1:0]   res_src, res_in, trial;
      logic [SIDE_W-1:0] side_src;
      logic              v_src, ge;

      if (s == 0) begin : g_first
         assign x_src    = in_rad;
         assign res_src  = '0;
         assign side_src = in_side;
         assign v_src    = in_valid;
      end else begin : g_next
         assign x_src    = x_ff[s-1];
         assign res_src  = res_ff[s-1];
         assign side_src = side_ff[s-1];
         assign v_src    = v_ff[s-1];
      end

      // Try the next root bit against the remaining radicand.
      always_comb begin
         trial  = res_src + BIT;
         ge     = RESW'(x_src) >= trial;
         x_in   = ge ? XW'(RESW'(x_src) - trial) : x_src;
         res_in = ge ? (res_src >> 1) + BIT : res_src >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[s]    <= x_in;
            res_ff[s]  <= res_in;
            side_ff[s] <= side_src;
         end
      end
   end

   assign out_valid = v_ff[F];
   assign out_root  = RW'(res_ff[F]);
   assign out_side  = side_ff[F];

endmodule

### hdl/snv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snv_back
// Two output stages: the scaled vector products, then the floor shift,
// saturation and the result register.
// ----------------------------------------------------------------------------
module snv_back #(
   parameter int FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [FRAC_BITS:0]     root,
   input  logic                   tir,
   input  logic [FRAC_BITS+1:0]   nc_f,
   input  logic [FRAC_BITS+1:0]   n,
   input  logic signed [15:0]     dx,
   input  logic signed [15:0]     dy,
   input  logic signed [15:0]     dz,
   input  logic signed [16:0]     nx,
   input  logic signed [16:0]     ny,
   input  logic signed [16:0]     nz,
   output logic                   rsp_valid,
   output snv_pkg::rsp_type       rsp_data
);
   import snv_pkg::*;

   localparam int F   = FRAC_BITS;
   localparam int NW  = F + 2;
   localparam int CFW = F + 3;
   localparam int PNW = NW + 17;
   localparam int PCW = CFW + 17;
   localparam int TW  = F + 21;

   // Stage 1: coefficient and the six products.
   logic signed [CFW-1:0] coef;
   logic signed [NW:0]    ns;
   logic                  v1_ff, tir1_ff;
   logic signed [PNW-1:0] pnx_ff, pny_ff, pnz_ff;
   logic signed [PCW-1:0] pcx_ff, pcy_ff, pcz_ff;

   always_comb begin
      coef = $signed(CFW'(nc_f)) - $signed(CFW'(root));
      ns   = $signed({1'b0, n});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tir1_ff <= tir;
         pnx_ff  <= ns * dx;
         pny_ff  <= ns * dy;
         pnz_ff  <= ns * dz;
         pcx_ff  <= coef * nx;
         pcy_ff  <= coef * ny;
         pcz_ff  <= coef * nz;
      end
   end

   // Stage 2: sum, floor shift, saturate; zero on total internal reflection.
   function automatic logic signed [COMP_W-1:0] fold(
      input logic signed [PNW-1:0] pn,
      input logic signed [PCW-1:0] pc
   );
      logic signed [TW-1:0] t;
      logic signed [TW-1:0] sh;
      t  = TW'(pn) + TW'(pc);
      sh = t >>> F;
      if (sh > TW'(SAT_MAX)) begin
         return SAT_MAX;
      end else if (sh < TW'(SAT_MIN)) begin
         return SAT_MIN;
      end
      return COMP_W'(sh);
   endfunction

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in.refracted = !tir1_ff;
      rsp_in.out_x     = tir1_ff ? '0 : fold(pnx_ff, pcx_ff);
      rsp_in.out_y     = tir1_ff ? '0 : fold(pny_ff, pcy_ff);
      rsp_in.out_z     = tir1_ff ? '0 : fold(pnz_ff, pcz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/snv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snv_checker
// Port-level checks of the refraction block, bound to its top level.
// ----------------------------------------------------------------------------
module snv_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_stall,
   input  logic             csr_we,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  snv_pkg::rsp_type rsp_data
);
   import snv_pkg::*;

   // The divider runs after reset, so no request transfer right away.
   a_reset_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken while index ratio not ready after reset");

   // A register write restarts the divider.
   a_write_stall: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_stall)
      else $error("request taken while index ratio recomputed");

   // A held response stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Total internal reflection gives a zero vector.
   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.refracted |->
         rsp_data.out_x == '0 && rsp_data.out_y == '0 && rsp_data.out_z == '0)
      else $error("nonzero vector on total internal reflection");

   // A stalled output freezes the pipeline, so requests must stall too.
   a_back_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while output held");

endmodule

bind snell_vector_refraction snv_checker u_snv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .csr_we    (csr_we),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
